// ===== rtl/core/sparse_life_patch_generation_top_macros.svh =====
// Assertion macros shared by the sparse Life patch generation RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SPARSE_LIFE_PATCH_GENERATION_TOP_MACROS_SVH
`define SPARSE_LIFE_PATCH_GENERATION_TOP_MACROS_SVH

// Checked outside reset only.
`define SLPG_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("slpg assertion failed");

// Checked in every cycle, reset included.
`define SLPG_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("slpg assertion failed");

`endif

// ===== rtl/core/slpg_pkg.sv =====
// Package for the sparse Life patch generation block: constants, rule table
// lookup function and the control struct between the core and result buffer.
// No dependencies.
`default_nettype none

package slpg_pkg;

   localparam int COORD_BITS_DEF = 24;

   localparam logic [7:0] MaskHi = 8'hCC;
   localparam logic [7:0] MaskLo = 8'h33;

   // Per table output bit 0..7: centre cell and neighbour masks of the 12-bit index.
   localparam logic [11:0] CellMask [8] = '{
      12'h080, 12'h010, 12'h020, 12'h040, 12'h008, 12'h001, 12'h002, 12'h004
   };
   localparam logic [11:0] NbrMask [8] = '{
      12'hD5D, 12'hBAB, 12'h757, 12'hEAE, 12'hDD5, 12'hBBA, 12'h775, 12'hEEA
   };

   typedef struct packed {
      logic load;
      logic two;
   } load_type;

   // One entry of the B3/S23 rule table, index = {page, index}.
   function automatic logic [7:0] rule_lookup(input logic [3:0] page,
                                              input logic [7:0] index);
      logic [11:0] idx;
      logic [11:0] nb;
      logic [3:0]  cnt;
      logic        alive;
      logic [7:0]  res;
      idx = {page, index};
      res = '0;
      for (int b = 0; b < 8; b++) begin
         nb = idx & NbrMask[b];
         cnt = '0;
         for (int i = 0; i < 12; i++) begin
            cnt = cnt + {3'b000, nb[i]};
         end
         alive = |(idx & CellMask[b]);
         res[b] = (cnt == 4'd3) || (alive && (cnt == 4'd2));
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slpg_kernel.sv =====
// Next-generation kernel: eight rule table lookups over a 2x2 neighbourhood
// of patch pairs. Depends on slpg_pkg.
`default_nettype none

module slpg_kernel (
   input  wire logic [15:0] ul,
   input  wire logic [15:0] ur,
   input  wire logic [15:0] ll,
   input  wire logic [15:0] lr,
   output logic      [15:0] bitmap
);
   import slpg_pkg::*;

   logic [7:0] ul0, ul1, ur0, ur1, ll0, lr0;
   logic [7:0] a, b;

   assign ul0 = ul[7:0];
   assign ul1 = ul[15:8];
   assign ur0 = ur[7:0];
   assign ur1 = ur[15:8];
   assign ll0 = ll[7:0];
   assign lr0 = lr[7:0];

   always_comb begin
      a = (rule_lookup(ul1[7:4], ul0) & 8'hC0)
        | (rule_lookup(ul0[3:0], ul1) & 8'h0C)
        | (rule_lookup({ur1[7:6], ul1[5:4]}, (ur0 & MaskHi) | (ul0 & MaskLo)) & 8'h30)
        | (rule_lookup({ur0[3:2], ul0[1:0]}, (ur1 & MaskHi) | (ul1 & MaskLo)) & 8'h03);
      b = (rule_lookup(ll0[7:4], ul1) & 8'hC0)
        | (rule_lookup(ul1[3:0], ll0) & 8'h0C)
        | (rule_lookup({lr0[7:6], ll0[5:4]}, (ur1 & MaskHi) | (ul1 & MaskLo)) & 8'h30)
        | (rule_lookup({ur1[3:2], ul1[1:0]}, (lr0 & MaskHi) | (ll0 & MaskLo)) & 8'h03);
   end

   assign bitmap = {b, a};

endmodule

`default_nettype wire

// ===== rtl/core/slpg_rsp_buf.sv =====
// Two-entry result register: holds the one or two results of an item and
// presents them in order on the rsp channel. Depends on slpg_pkg and macros.
`default_nettype none
`include "sparse_life_patch_generation_top_macros.svh"

module slpg_rsp_buf #(
   parameter  int COORD_BITS = slpg_pkg::COORD_BITS_DEF,
   localparam int RspDataW   = ((COORD_BITS + 16 + 7) / 8) * 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire slpg_pkg::load_type      ctrl,
   input  wire logic [COORD_BITS-1:0]   first_x,
   input  wire logic [15:0]             first_bmp,
   input  wire logic [COORD_BITS-1:0]   final_x,
   input  wire logic [15:0]             final_bmp,
   output logic                         free,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RspDataW-1:0]          rsp_tdata,  // out_x, new_bitmap, zero pad
   output logic                         rsp_tlast
);
   import slpg_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  head_ff, head_in;
   logic [COORD_BITS-1:0] e0_x_ff, e1_x_ff;
   logic [15:0]           e0_bmp_ff, e1_bmp_ff;
   logic [COORD_BITS-1:0] sel_x;
   logic [15:0]           sel_bmp;

   assign free = !valid_ff || (rsp_tready && head_ff);

   always_comb begin
      valid_in = valid_ff;
      head_in  = head_ff;
      if (ctrl.load) begin
         valid_in = 1'b1;
         head_in  = !ctrl.two;
      end else if (valid_ff && rsp_tready) begin
         if (head_ff) begin
            valid_in = 1'b0;
         end else begin
            head_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         head_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         e0_x_ff   <= first_x;
         e0_bmp_ff <= first_bmp;
         e1_x_ff   <= final_x;
         e1_bmp_ff <= final_bmp;
      end
   end

   assign sel_x      = head_ff ? e1_x_ff : e0_x_ff;
   assign sel_bmp    = head_ff ? e1_bmp_ff : e0_bmp_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = head_ff;
   assign rsp_tdata  = RspDataW'({sel_bmp, sel_x});

   `SLPG_ASSERT(a_load_when_free, clock, reset, ctrl.load |-> free)
   `SLPG_ASSERT(a_second_follows, clock, reset,
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tlast))
   `SLPG_ASSERT(a_bitmap_nonzero, clock, reset, rsp_tvalid |-> (sel_bmp != 16'h0000))
   `SLPG_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

`default_nettype wire

// ===== rtl/core/sparse_life_patch_generation_top.sv =====
// Sparse Life patch generation: one merged column of a row group per req
// transfer (kind in tuser; col_x, upper and lower pairs in tdata) gives zero,
// one or two rsp transfers of (out_x, new_bitmap), tlast on the final one.
// A column is taken every cycle unless the input register is full and the
// result register busy; the rsp side delivers one result a cycle while
// rsp_tready is high, so a column that flushes a pending left column and
// also yields its own patch holds the output register until both are taken.
// From req to rsp: an input register, then the two rule-table kernels feeding
// the result register. Reset clears the kept left column and both stages.
`default_nettype none

module sparse_life_patch_generation_top #(
   parameter  int COORD_BITS = slpg_pkg::COORD_BITS_DEF,
   localparam int ReqDataW   = ((COORD_BITS + 32 + 7) / 8) * 8,
   localparam int RspDataW   = ((COORD_BITS + 16 + 7) / 8) * 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,  // col_x, upper_patch, lower_patch, pad
   input  wire logic                req_tuser,  // kind
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RspDataW-1:0]      rsp_tdata,  // out_x, new_bitmap, pad
   output logic                     rsp_tlast
);
   import slpg_pkg::*;

   logic                  req_xfer;
   logic [COORD_BITS-1:0] in_x;
   logic [15:0]           in_up, in_lo;
   logic                  in_flush;

   logic [15:0]           left_upper_ff, left_upper_in;
   logic [15:0]           left_lower_ff, left_lower_in;
   logic [COORD_BITS-1:0] left_x_ff, left_x_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_flush_ff, s1_main_ff;
   logic [15:0]           s1_lu_ff, s1_ll_ff, s1_up_ff, s1_lo_ff;
   logic [COORD_BITS-1:0] s1_x_ff, s1_lx_ff;

   logic [15:0]           main_lu, main_ll;
   logic [15:0]           fl_bmp, mn_bmp;
   logic                  fl_hit, mn_hit;
   logic                  buf_free;
   load_type              buf_ctrl;
   logic [COORD_BITS-1:0] fl_x, mn_x;

   assign req_xfer = req_tvalid && req_tready;
   assign in_x     = req_tdata[COORD_BITS-1:0];
   assign in_up    = req_tdata[COORD_BITS+15 -: 16];
   assign in_lo    = req_tdata[COORD_BITS+31 -: 16];
   // Flushing with nothing pending yields an all-zero bitmap, so no qualifier needed.
   assign in_flush = req_tuser || (in_x != (left_x_ff + COORD_BITS'(4)));

   always_comb begin
      left_upper_in = left_upper_ff;
      left_lower_in = left_lower_ff;
      left_x_in     = left_x_ff;
      if (req_xfer) begin
         if (req_tuser) begin
            left_upper_in = '0;
            left_lower_in = '0;
            left_x_in     = '0;
         end else begin
            left_upper_in = in_up;
            left_lower_in = in_lo;
            left_x_in     = in_x;
         end
      end
   end

   assign req_tready  = !s1_valid_ff || buf_free;
   assign s1_valid_in = req_xfer ? 1'b1 : (buf_free ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_upper_ff <= '0;
         left_lower_ff <= '0;
         left_x_ff     <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         left_upper_ff <= left_upper_in;
         left_lower_ff <= left_lower_in;
         left_x_ff     <= left_x_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_flush_ff <= in_flush;
         s1_main_ff  <= !req_tuser;
         s1_lu_ff    <= left_upper_ff;
         s1_ll_ff    <= left_lower_ff;
         s1_up_ff    <= in_up;
         s1_lo_ff    <= in_lo;
         s1_x_ff     <= in_x;
         s1_lx_ff    <= left_x_ff;
      end
   end

   assign main_lu = s1_flush_ff ? 16'h0000 : s1_lu_ff;
   assign main_ll = s1_flush_ff ? 16'h0000 : s1_ll_ff;

   slpg_kernel u_flush_kernel (
      .ul     (s1_lu_ff),
      .ur     (16'h0000),
      .ll     (s1_ll_ff),
      .lr     (16'h0000),
      .bitmap (fl_bmp)
   );

   slpg_kernel u_main_kernel (
      .ul     (main_lu),
      .ur     (s1_up_ff),
      .ll     (main_ll),
      .lr     (s1_lo_ff),
      .bitmap (mn_bmp)
   );

   assign fl_hit = s1_flush_ff && (fl_bmp != 16'h0000);
   assign mn_hit = s1_main_ff && (mn_bmp != 16'h0000);
   assign fl_x   = s1_lx_ff + COORD_BITS'(1);
   assign mn_x   = s1_x_ff - COORD_BITS'(3);

   assign buf_ctrl.load = s1_valid_ff && buf_free && (fl_hit || mn_hit);
   assign buf_ctrl.two  = fl_hit && mn_hit;

   slpg_rsp_buf #(
      .COORD_BITS (COORD_BITS)
   ) u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (buf_ctrl),
      .first_x    (fl_x),
      .first_bmp  (fl_bmp),
      .final_x    (mn_hit ? mn_x : fl_x),
      .final_bmp  (mn_hit ? mn_bmp : fl_bmp),
      .free       (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== tb/sv/sparse_life_patch_generation_top_tb.sv =====
// Self-checking bench for sparse_life_patch_generation_top: columns stream in,
// patch results are predicted from the B3/S23 kernel and checked in order.
// Depends only on the RTL of the block; no files, no arguments.
module sparse_life_patch_generation_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_W = 56;
   localparam int RSP_W = 40;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 400;
   localparam logic KIND_COLUMN = 1'b0;
   localparam logic KIND_ROW_END = 1'b1;

   // bit b of a rule entry: centre cell and neighbour masks, bit 0 lowest
   localparam logic [95:0] CENTRE_MASKS = {12'h004, 12'h002, 12'h001, 12'h008,
                                           12'h040, 12'h020, 12'h010, 12'h080};
   localparam logic [95:0] NEIGHBOUR_MASKS = {12'hEEA, 12'h775, 12'hBBA, 12'hDD5,
                                              12'hEAE, 12'h757, 12'hBAB, 12'hD5D};
   localparam logic [7:0] SIDE_HI = 8'hCC;
   localparam logic [7:0] SIDE_LO = 8'h33;

   typedef struct {
      logic        kind;
      logic [23:0] x;
      logic [15:0] upper;
      logic [15:0] lower;
      int          gap;
   } column_type;

   typedef struct {
      logic [23:0] x;
      logic [15:0] bitmap;
      logic        last;
   } patch_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // col_x, upper_patch, lower_patch
   logic             req_tuser;   // kind
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // out_x, new_bitmap
   logic             rsp_tlast;

   column_type column_feed[$];
   patch_type  patch_expect[$];
   patch_type  step_out[$];

   logic [15:0] prev_upper = '0;
   logic [15:0] prev_lower = '0;
   logic [23:0] prev_x = '0;

   int     column_total = 0;
   int     columns_taken = 0;
   int     row_ends_taken = 0;
   int     patches_checked = 0;
   int     flushes = 0;
   int     mismatches = 0;
   int     cycles = 0;
   int     gap_left = -1;
   int     rsp_stall = -1;
   int     hold_left = 0;
   logic   hold_done = 1'b0;
   logic   rsp_hold = 1'b0;
   logic   req_taken = 1'b0;
   logic   rsp_taken = 1'b0;
   column_type drive_col;

   sparse_life_patch_generation_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   function automatic logic [7:0] life_rule(input logic [3:0] page, input logic [7:0] index);
      logic [11:0] idx;
      int          cnt;
      logic [7:0]  r;
      idx = {page, index};
      r = '0;
      for (int b = 0; b < 8; b++) begin
         cnt = $countones(idx & NEIGHBOUR_MASKS[b*12 +: 12]);
         if (|(idx & CENTRE_MASKS[b*12 +: 12])) r[b] = (cnt == 2) || (cnt == 3);
         else r[b] = (cnt == 3);
      end
      return r;
   endfunction

   function automatic logic [15:0] next_pair(input logic [15:0] ul, input logic [15:0] ur,
                                             input logic [15:0] ll, input logic [15:0] lr);
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] mid;
      logic [7:0] t;
      mid = (ur[15:8] & SIDE_HI) | (ul[15:8] & SIDE_LO);
      t = life_rule(ul[15:12], ul[7:0]);                  a[7:6] = t[7:6];
      t = life_rule(ul[3:0], ul[15:8]);                   a[3:2] = t[3:2];
      t = life_rule({ur[15:14], ul[13:12]},
                    (ur[7:0] & SIDE_HI) | (ul[7:0] & SIDE_LO)); a[5:4] = t[5:4];
      t = life_rule({ur[3:2], ul[1:0]}, mid);             a[1:0] = t[1:0];
      t = life_rule(ll[7:4], ul[15:8]);                   b[7:6] = t[7:6];
      t = life_rule(ul[11:8], ll[7:0]);                   b[3:2] = t[3:2];
      t = life_rule({lr[7:6], ll[5:4]}, mid);             b[5:4] = t[5:4];
      t = life_rule({ur[11:10], ul[9:8]},
                    (lr[7:0] & SIDE_HI) | (ll[7:0] & SIDE_LO)); b[1:0] = t[1:0];
      return {b, a};
   endfunction

   function automatic void queue_patch(input logic [23:0] x, input logic [15:0] bmp);
      patch_type p;
      if (bmp != 16'h0) begin
         p.x = x;
         p.bitmap = bmp;
         p.last = 1'b0;
         step_out.push_back(p);
      end
   endfunction

   function automatic void flush_left_column();
      if ((prev_upper | prev_lower) != 16'h0) begin
         flushes++;
         queue_patch(prev_x + 24'd1, next_pair(prev_upper, 16'h0, prev_lower, 16'h0));
      end
      prev_upper = '0;
      prev_lower = '0;
   endfunction

   function automatic void predict_column(input logic kind, input logic [23:0] x,
                                          input logic [15:0] up, input logic [15:0] lo);
      step_out.delete();
      if (kind == KIND_ROW_END) begin
         flush_left_column();
         prev_x = '0;
      end else begin
         if ((prev_upper | prev_lower) != 16'h0 && x != prev_x + 24'd4)
            flush_left_column();
         if ((prev_upper | prev_lower | up | lo) != 16'h0)
            queue_patch(x - 24'd3, next_pair(prev_upper, up, prev_lower, lo));
         prev_upper = up;
         prev_lower = lo;
         prev_x = x;
      end
      if (step_out.size() != 0) step_out[step_out.size()-1].last = 1'b1;
      foreach (step_out[i]) patch_expect.push_back(step_out[i]);
   endfunction

   function automatic void add_column(input logic kind, input logic [23:0] x,
                                      input logic [15:0] up, input logic [15:0] lo);
      column_type c;
      int      n;
      n = column_feed.size();
      c.kind = kind;
      c.x = x;
      c.upper = up;
      c.lower = lo;
      if ((n >= HOLD_AT - 10 && n < HOLD_AT + 100) || (n / 80) % 3 == 2) c.gap = 0;
      else c.gap = $urandom_range(19, 0);
      column_feed.push_back(c);
   endfunction

   function automatic logic [15:0] random_pair();
      int pick;
      pick = $urandom_range(99, 0);
      if (pick < 25) return 16'h0;
      if (pick < 55) return 16'($urandom & $urandom);
      if (pick < 90) return 16'($urandom);
      if (pick < 95) return 16'hFFFF;
      return 16'h1 << $urandom_range(15, 0);
   endfunction

   // transfer bookkeeping, prediction and checking
   always @(posedge clock) begin
      patch_type want;
      logic [23:0] got_x;
      logic [15:0] got_bmp;
      req_taken <= req_tvalid && req_tready;
      rsp_taken <= rsp_tvalid && rsp_tready;
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d patches still expected", $realtime, patch_expect.size());
         $display("Some tests failed");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_column(req_tuser, req_tdata[23:0], req_tdata[39:24], req_tdata[55:40]);
            columns_taken++;
            if (req_tuser == KIND_ROW_END) row_ends_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_x = rsp_tdata[23:0];
            got_bmp = rsp_tdata[39:24];
            if (patch_expect.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected patch x=%0d bitmap=%h last=%b", $realtime,
                        $signed(got_x), got_bmp, rsp_tlast);
            end else begin
               want = patch_expect.pop_front();
               patches_checked++;
               if (got_x !== want.x || got_bmp !== want.bitmap
                   || rsp_tlast !== want.last) begin
                  mismatches++;
                  $display({"%0t: patch mismatch, expected x=%0d bitmap=%h last=%b,",
                            " got x=%0d bitmap=%h last=%b"},
                           $realtime, $signed(want.x), want.bitmap, want.last,
                           $signed(got_x), got_bmp, rsp_tlast);
               end
            end
         end
      end
   end

   // column driver
   always @(negedge clock) begin
      if (!reset && !(req_tvalid && !req_taken)) begin
         if (column_feed.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            if (gap_left < 0) gap_left = column_feed[0].gap;
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               drive_col = column_feed.pop_front();
               gap_left = -1;
               req_tvalid <= 1'b1;
               req_tuser <= drive_col.kind;
               req_tdata <= {drive_col.lower, drive_col.upper, drive_col.x};
            end
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken || rsp_stall < 0)
            rsp_stall = ((patches_checked / 70) % 3 == 1) ? 0 : $urandom_range(19, 0);
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // one long back-pressure stretch while columns keep coming
   always @(negedge clock) begin
      if (!hold_done && columns_taken >= HOLD_AT) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) hold_left--;
      rsp_hold <= (hold_left > 0);
   end

   initial begin
      int x;
      int nx;
      int len;
      int pick;
      int random_cols;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;

      // directed columns
      add_column(KIND_ROW_END, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
      add_column(KIND_COLUMN, -24'sd8388604, 16'h0000, 16'h0000);
      add_column(KIND_COLUMN, -24'sd8388600, 16'h0660, 16'h0000);
      add_column(KIND_COLUMN, -24'sd8388596, 16'hFFFF, 16'hFFFF);
      add_column(KIND_COLUMN, -24'sd8388592, 16'h0000, 16'hFFFF);
      add_column(KIND_COLUMN, -24'sd8388588, 16'h0000, 16'h0000);
      add_column(KIND_COLUMN, -24'sd8388584, 16'h0000, 16'h0000);
      add_column(KIND_COLUMN, -24'sd100, 16'h0F0F, 16'hF0F0);
      add_column(KIND_COLUMN, -24'sd96, 16'h1234, 16'h8001);
      add_column(KIND_COLUMN, -24'sd60, 16'h0101, 16'h8080);
      add_column(KIND_COLUMN, -24'sd200, 16'h00FF, 16'h0000);
      add_column(KIND_ROW_END, 24'h0, 16'h0, 16'h0);
      add_column(KIND_COLUMN, -24'sd8, 16'h0007, 16'h0000);
      add_column(KIND_COLUMN, -24'sd4, 16'h0700, 16'h0000);
      add_column(KIND_COLUMN, -24'sd1, 16'hFFFF, 16'hFFFF);
      add_column(KIND_ROW_END, 24'h5A5A5A, 16'hA5A5, 16'h5A5A);
      add_column(KIND_COLUMN, -24'sd1000, 16'h0001, 16'h0000);
      add_column(KIND_ROW_END, 24'h0, 16'h0, 16'h0);
      add_column(KIND_COLUMN, -24'sd2000, 16'h0000, 16'h0E00);
      add_column(KIND_COLUMN, -24'sd1996, 16'h0000, 16'h0E00);
      add_column(KIND_COLUMN, -24'sd1996, 16'h2000, 16'h0040);
      add_column(KIND_ROW_END, 24'h0, 16'h0, 16'h0);

      // random row groups
      random_cols = 0;
      while (random_cols < 600) begin
         x = -int'($urandom_range(8388604, 4));
         len = $urandom_range(30, 1);
         for (int i = 0; i < len; i++) begin
            add_column(KIND_COLUMN, x[23:0], random_pair(), random_pair());
            random_cols++;
            if ($urandom_range(99, 0) < 3)
               add_column(KIND_ROW_END, 24'($urandom), 16'($urandom), 16'($urandom));
            pick = $urandom_range(99, 0);
            if (pick < 85) nx = x + 4;
            else if (pick < 93) nx = x + 4 * int'($urandom_range(16, 2));
            else if (pick < 97) nx = x - 4 * int'($urandom_range(16, 0));
            else nx = -int'($urandom_range(8388604, 4));
            if (nx > -1 || nx < -8388604) break;
            x = nx;
         end
         if ($urandom_range(9, 0) != 0)
            add_column(KIND_ROW_END, 24'($urandom), 16'($urandom), 16'($urandom));
      end
      add_column(KIND_ROW_END, 24'h0, 16'h0, 16'h0);
      column_total = column_feed.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (columns_taken < column_total) @(negedge clock);
      while (patch_expect.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Streamed %0d transfers (%0d row ends), checked %0d patches", columns_taken,
               row_ends_taken, patches_checked);
      $display("Left-column flushes on gaps, reversals and row ends: %0d", flushes);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
